### src/bptc_pkg.sv
// Package for the barometric pressure and temperature compensation block.
// Holds field widths, calibration register codes, constants and stage structs.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bptc_pkg;

    // Field and datapath widths
    localparam int CalW      = 16;   // calibration word
    localparam int RawW      = 24;   // raw conversion result
    localparam int CfgIdxW   = 3;    // configuration register index
    localparam int DtW       = 25;   // dT = D2 - C5*2^8
    localparam int ProdW     = 42;   // dT times a calibration word
    localparam int DtSqW     = 50;   // dT squared
    localparam int DiffW     = 19;   // TEMP - 2000, and TEMP + 1500
    localparam int T2W       = 18;   // T2 correction, never negative
    localparam int TempW     = 20;   // temperature before saturation
    localparam int OffW      = 36;   // first-order offset
    localparam int SensW     = 35;   // first-order sensitivity
    localparam int SqW       = 36;   // squared temperature difference
    localparam int CorrW     = 38;   // OFF2 and SENS2
    localparam int AdjW      = 40;   // OFF - OFF2 and SENS - SENS2
    localparam int HalfW     = 20;   // split of the sensitivity for the pressure multiply
    localparam int LoProdW   = 44;   // D1 times low half
    localparam int HiProdW   = 45;   // D1 times high half
    localparam int FullW     = 64;   // D1 times sensitivity
    localparam int PreW      = 44;   // D1*SENS/2^21 - OFF
    localparam int PressW    = 29;   // pressure before saturation
    localparam int TempOutW  = 15;
    localparam int PressOutW = 17;

    // Compensation constants
    localparam int TEMP_REF   = 2000;
    localparam int COLD_SPAN  = 3500;  // 2000 - (-1500)
    localparam int TEMP_MIN   = -4000;
    localparam int TEMP_MAX   = 8500;
    localparam int PRESS_MIN  = 1000;
    localparam int PRESS_MAX  = 120000;

    // Calibration register codes
    typedef enum logic [CfgIdxW-1:0] {
        CAL_PRESSURE_SENSITIVITY   = 3'd0,
        CAL_PRESSURE_OFFSET        = 3'd1,
        CAL_SENSITIVITY_TEMP_COEFF = 3'd2,
        CAL_OFFSET_TEMP_COEFF      = 3'd3,
        CAL_REFERENCE_TEMPERATURE  = 3'd4,
        CAL_TEMPERATURE_COEFF      = 3'd5
    } t_cal_idx;

    // Calibration words C1..C6
    typedef struct packed {
        logic [CalW-1:0] c1;
        logic [CalW-1:0] c2;
        logic [CalW-1:0] c3;
        logic [CalW-1:0] c4;
        logic [CalW-1:0] c5;
        logic [CalW-1:0] c6;
    } t_cal;

    localparam t_cal CAL_RESET = '{
        c1: 16'd40127,
        c2: 16'd36924,
        c3: 16'd23317,
        c4: 16'd23282,
        c5: 16'd33464,
        c6: 16'd28312
    };

    // Front end to correction stage
    typedef struct packed {
        logic signed [TempW-1:0] temp;
        logic [SqW-1:0]          sq_a;
        logic [SqW-1:0]          sq_b;
        logic signed [OffW-1:0]  off;
        logic signed [SensW-1:0] sens;
        logic                    cold;
        logic                    very_cold;
        logic [RawW-1:0]         raw_pressure;
    } t_front;

    // Correction stage to pressure stage
    typedef struct packed {
        logic signed [TempW-1:0] temp;
        logic signed [AdjW-1:0]  off_adj;
        logic signed [AdjW-1:0]  sens_adj;
        logic [RawW-1:0]         raw_pressure;
    } t_corr;

endpackage

`default_nettype wire

### src/baro_pressure_temp_compensation.sv
// Barometric second-order compensation, ten-stage pipeline.
// Throughput: one transaction per cycle while the output is not stalled;
// the stall chain lets empty stages fill. Stage depth is set by the 25-bit
// dT products and the split 24x40 pressure multiply.
// Reset: synchronous, clears all stage valid bits and loads the calibration defaults.
`default_nettype none

module baro_pressure_temp_compensation (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Sample channel
    input  wire logic                           i_valid,
    output wire logic                           o_stall,
    input  wire logic [bptc_pkg::RawW-1:0]      i_raw_temperature,
    input  wire logic [bptc_pkg::RawW-1:0]      i_raw_pressure,
    // Result channel
    output wire logic                           o_valid,
    input  wire logic                           i_stall,
    output wire logic [bptc_pkg::TempOutW-1:0]  o_temp_centideg,
    output wire logic [bptc_pkg::PressOutW-1:0] o_pressure_pa,
    output wire logic                           o_clamped,
    // Calibration write channel
    input  wire logic                           i_cfg_valid,
    output wire logic                           o_cfg_ready,
    input  wire logic [bptc_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [bptc_pkg::CalW-1:0]      i_cfg_data
);
    import bptc_pkg::*;

    t_cal   cal;
    t_front front_data;
    t_corr  corr_data;
    logic   front_valid;
    logic   front_stall;
    logic   corr_valid;
    logic   corr_stall;

    // Calibration writes are always taken
    assign o_cfg_ready = 1'b1;

    bptc_cal_regs u_cal_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cal      (cal)
    );

    bptc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cal             (cal),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .o_valid           (front_valid),
        .i_stall           (front_stall),
        .o_data            (front_data)
    );

    bptc_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_stall (front_stall),
        .i_data  (front_data),
        .o_valid (corr_valid),
        .i_stall (corr_stall),
        .o_data  (corr_data)
    );

    bptc_press u_press (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (corr_valid),
        .o_stall         (corr_stall),
        .i_data          (corr_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_temp_centideg (o_temp_centideg),
        .o_pressure_pa   (o_pressure_pa),
        .o_clamped       (o_clamped)
    );

endmodule

`default_nettype wire

### src/bptc_cal_regs.sv
// Calibration register file, six 16-bit words written through the config channel.
// Depends on bptc_pkg.
`default_nettype none

module bptc_cal_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_wr_en,
    input  wire logic [bptc_pkg::CfgIdxW-1:0] i_wr_index,
    input  wire logic [bptc_pkg::CalW-1:0]    i_wr_data,
    output bptc_pkg::t_cal                    o_cal
);
    import bptc_pkg::*;

    t_cal r_cal;

    // Write one word per transaction; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= CAL_RESET;
        end else if (i_wr_en) begin
            case (t_cal_idx'(i_wr_index))
                CAL_PRESSURE_SENSITIVITY:   r_cal.c1 <= i_wr_data;
                CAL_PRESSURE_OFFSET:        r_cal.c2 <= i_wr_data;
                CAL_SENSITIVITY_TEMP_COEFF: r_cal.c3 <= i_wr_data;
                CAL_OFFSET_TEMP_COEFF:      r_cal.c4 <= i_wr_data;
                CAL_REFERENCE_TEMPERATURE:  r_cal.c5 <= i_wr_data;
                CAL_TEMPERATURE_COEFF:      r_cal.c6 <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cal = r_cal;

endmodule

`default_nettype wire

### src/bptc_front.sv
// Front end, four stages: dT, calibration products, first-order terms, squares.
// Depends on bptc_pkg.
`default_nettype none

module bptc_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  bptc_pkg::t_cal                 i_cal,
    input  wire logic                      i_valid,
    output wire logic                      o_stall,
    input  wire logic [bptc_pkg::RawW-1:0] i_raw_temperature,
    input  wire logic [bptc_pkg::RawW-1:0] i_raw_pressure,
    output wire logic                      o_valid,
    input  wire logic                      i_stall,
    output bptc_pkg::t_front               o_data
);
    import bptc_pkg::*;

    localparam int NStg = 4;

    logic [NStg-1:0] r_v;
    logic [NStg-1:0] en;

    // Stage 1
    logic signed [DtW-1:0]   r1_dt;
    logic [RawW-1:0]         r1_d1;
    // Stage 2
    logic signed [ProdW-1:0] r2_p6;
    logic signed [ProdW-1:0] r2_p4;
    logic signed [ProdW-1:0] r2_p3;
    logic signed [DtSqW-1:0] r2_pdd;
    logic [RawW-1:0]         r2_d1;
    // Stage 3
    logic signed [DiffW-1:0] r3_a;
    logic signed [DiffW-1:0] r3_b;
    logic signed [OffW-1:0]  r3_off;
    logic signed [SensW-1:0] r3_sens;
    logic [T2W-1:0]          r3_t2;
    logic [RawW-1:0]         r3_d1;
    // Stage 4
    t_front                  r4;

    logic signed [DiffW-1:0] n3_a;
    logic signed [2*DiffW-1:0] n4_sq_a;
    logic signed [2*DiffW-1:0] n4_sq_b;
    logic signed [TempW-1:0] n4_temp1;
    logic signed [TempW-1:0] n4_t2;

    // A stage advances when it is empty or the next one advances
    assign en[3] = !r_v[3] || !i_stall;
    assign en[2] = !r_v[2] || en[3];
    assign en[1] = !r_v[1] || en[2];
    assign en[0] = !r_v[0] || en[1];
    assign o_stall = !en[0];
    assign o_valid = r_v[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
        end
    end

    // Temperature difference from the reference
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_dt <= $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_cal.c5, 8'h00});
            r1_d1 <= i_raw_pressure;
        end
    end

    // Products of dT with C6, C4, C3 and with itself
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_p6  <= r1_dt * $signed({1'b0, i_cal.c6});
            r2_p4  <= r1_dt * $signed({1'b0, i_cal.c4});
            r2_p3  <= r1_dt * $signed({1'b0, i_cal.c3});
            r2_pdd <= r1_dt * r1_dt;
            r2_d1  <= r1_d1;
        end
    end

    // First-order offset and sensitivity, TEMP - 2000 and TEMP + 1500
    assign n3_a = r2_p6[ProdW-1:23];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_a    <= n3_a;
            r3_b    <= n3_a + DiffW'(COLD_SPAN);
            r3_off  <= $signed({4'b0, i_cal.c2, 16'h0000})
                     + $signed({r2_p4[ProdW-1], r2_p4[ProdW-1:7]});
            r3_sens <= $signed({4'b0, i_cal.c1, 15'h0000})
                     + $signed({r2_p3[ProdW-1], r2_p3[ProdW-1:8]});
            r3_t2   <= r2_pdd[48:31];
            r3_d1   <= r2_d1;
        end
    end

    // Squares for the second-order terms, temperature minus T2
    assign n4_sq_a  = r3_a * r3_a;
    assign n4_sq_b  = r3_b * r3_b;
    assign n4_temp1 = TempW'(r3_a) + TempW'(TEMP_REF);
    assign n4_t2    = r3_a[DiffW-1] ? $signed({2'b00, r3_t2}) : '0;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4.temp         <= n4_temp1 - n4_t2;
            r4.sq_a         <= n4_sq_a[SqW-1:0];
            r4.sq_b         <= n4_sq_b[SqW-1:0];
            r4.off          <= r3_off;
            r4.sens         <= r3_sens;
            r4.cold         <= r3_a[DiffW-1];
            r4.very_cold    <= r3_b[DiffW-1];
            r4.raw_pressure <= r3_d1;
        end
    end

    assign o_data = r4;

endmodule

`default_nettype wire

### src/bptc_corr.sv
// Second-order correction, two stages: OFF2 and SENS2, then their subtraction.
// Depends on bptc_pkg.
`default_nettype none

module bptc_corr (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output wire logic         o_stall,
    input  bptc_pkg::t_front  i_data,
    output wire logic         o_valid,
    input  wire logic         i_stall,
    output bptc_pkg::t_corr   o_data
);
    import bptc_pkg::*;

    logic [1:0] r_v;
    logic [1:0] en;

    logic [CorrW-1:0]        n_five_sq;
    logic [CorrW:0]          n_seven_sq;
    logic [CorrW+1:0]        n_eleven_sq;
    logic [CorrW-1:0]        n_off2;
    logic [CorrW-1:0]        n_sens2;

    logic [CorrW-1:0]        r_off2;
    logic [CorrW-1:0]        r_sens2;
    logic signed [OffW-1:0]  r_off;
    logic signed [SensW-1:0] r_sens;
    logic signed [TempW-1:0] r_temp;
    logic [RawW-1:0]         r_d1;
    t_corr                   r_out;

    assign en[1] = !r_v[1] || !i_stall;
    assign en[0] = !r_v[0] || en[1];
    assign o_stall = !en[0];
    assign o_valid = r_v[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
        end
    end

    // Build 5*sq, 7*sq2 and 11*sq2 from shifts and adds
    assign n_five_sq   = {2'b00, i_data.sq_a} + {i_data.sq_a, 2'b00};
    assign n_seven_sq  = {i_data.sq_b, 3'b000} - {3'b000, i_data.sq_b};
    assign n_eleven_sq = {i_data.sq_b, 3'b000} + {2'b00, i_data.sq_b, 1'b0}
                       + {4'b0000, i_data.sq_b};

    always_comb begin
        n_off2  = '0;
        n_sens2 = '0;
        if (i_data.cold) begin
            n_off2  = {1'b0, n_five_sq[CorrW-1:1]};
            n_sens2 = {2'b00, n_five_sq[CorrW-1:2]};
            if (i_data.very_cold) begin
                n_off2  = n_off2 + n_seven_sq[CorrW-1:0];
                n_sens2 = n_sens2 + n_eleven_sq[CorrW:1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_off2  <= n_off2;
            r_sens2 <= n_sens2;
            r_off   <= i_data.off;
            r_sens  <= i_data.sens;
            r_temp  <= i_data.temp;
            r_d1    <= i_data.raw_pressure;
        end
    end

    // Apply the corrections
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_out.off_adj      <= AdjW'(r_off) - $signed({2'b00, r_off2});
            r_out.sens_adj     <= AdjW'(r_sens) - $signed({2'b00, r_sens2});
            r_out.temp         <= r_temp;
            r_out.raw_pressure <= r_d1;
        end
    end

    assign o_data = r_out;

endmodule

`default_nettype wire

### src/bptc_press.sv
// Pressure stages: split D1*SENS multiply, recombine, subtract OFF, saturate.
// Also saturates the temperature. Depends on bptc_pkg.
`default_nettype none

module bptc_press (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output wire logic                           o_stall,
    input  bptc_pkg::t_corr                     i_data,
    output wire logic                           o_valid,
    input  wire logic                           i_stall,
    output wire logic [bptc_pkg::TempOutW-1:0]  o_temp_centideg,
    output wire logic [bptc_pkg::PressOutW-1:0] o_pressure_pa,
    output wire logic                           o_clamped
);
    import bptc_pkg::*;

    localparam int NStg = 4;

    logic [NStg-1:0] r_v;
    logic [NStg-1:0] en;

    // Stage 7
    logic [LoProdW-1:0]        r7_lo;
    logic signed [HiProdW-1:0] r7_hi;
    logic signed [AdjW-1:0]    r7_off;
    logic signed [TempW-1:0]   r7_temp;
    // Stage 8
    logic signed [FullW-1:0]   r8_prod;
    logic signed [AdjW-1:0]    r8_off;
    logic signed [TempW-1:0]   r8_temp;
    // Stage 9
    logic signed [PreW-1:0]    r9_pre;
    logic signed [TempW-1:0]   r9_temp;
    // Stage 10
    logic [TempOutW-1:0]       r_temp_out;
    logic [PressOutW-1:0]      r_press_out;
    logic                      r_clamped;

    logic signed [PressW-1:0]  n_press;
    logic signed [TempW-1:0]   n_temp_sat;
    logic signed [PressW-1:0]  n_press_sat;
    logic                      n_clamped;

    assign en[3] = !r_v[3] || !i_stall;
    assign en[2] = !r_v[2] || en[3];
    assign en[1] = !r_v[1] || en[2];
    assign en[0] = !r_v[0] || en[1];
    assign o_stall = !en[0];
    assign o_valid = r_v[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
        end
    end

    // Partial products of D1 with the low and high halves of SENS
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r7_lo   <= i_data.raw_pressure * i_data.sens_adj[HalfW-1:0];
            r7_hi   <= $signed({1'b0, i_data.raw_pressure})
                     * $signed(i_data.sens_adj[AdjW-1:HalfW]);
            r7_off  <= i_data.off_adj;
            r7_temp <= i_data.temp;
        end
    end

    // Recombine into the full product
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r8_prod <= $signed({r7_hi[FullW-HalfW-1:0], {HalfW{1'b0}}})
                     + $signed({{(FullW-LoProdW){1'b0}}, r7_lo});
            r8_off  <= r7_off;
            r8_temp <= r7_temp;
        end
    end

    // Scale by 2^-21 and remove the offset
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r9_pre  <= $signed({r8_prod[FullW-1], r8_prod[FullW-1:21]}) - PreW'(r8_off);
            r9_temp <= r8_temp;
        end
    end

    // Scale by 2^-15 and saturate both results
    assign n_press = r9_pre[PreW-1:15];

    always_comb begin
        n_clamped   = 1'b0;
        n_temp_sat  = r9_temp;
        n_press_sat = n_press;
        if (r9_temp < TempW'(TEMP_MIN)) begin
            n_temp_sat = TempW'(TEMP_MIN);
            n_clamped  = 1'b1;
        end
        if (r9_temp > TempW'(TEMP_MAX)) begin
            n_temp_sat = TempW'(TEMP_MAX);
            n_clamped  = 1'b1;
        end
        if (n_press < PressW'(PRESS_MIN)) begin
            n_press_sat = PressW'(PRESS_MIN);
            n_clamped   = 1'b1;
        end
        if (n_press > PressW'(PRESS_MAX)) begin
            n_press_sat = PressW'(PRESS_MAX);
            n_clamped   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_temp_out  <= n_temp_sat[TempOutW-1:0];
            r_press_out <= n_press_sat[PressOutW-1:0];
            r_clamped   <= n_clamped;
        end
    end

    assign o_temp_centideg = r_temp_out;
    assign o_pressure_pa   = r_press_out;
    assign o_clamped       = r_clamped;

endmodule

`default_nettype wire
